// File: rtl/pmpid_pkg.sv
// Package for the period-measuring PID speed loop.
// Holds the timer and gain scaling constants, register indexes and the stage tag type.
// No dependencies; the top level, front end, MAC, scale and check files import it.
package pmpid_pkg;

	localparam int unsigned TIMER_TOP    = 1024;
	localparam int unsigned GAIN_DIVISOR = 50000;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT   = 3'd4;

	localparam logic [15:0] GAIN_P_RST        = 16'd250;
	localparam logic [15:0] GAIN_I_RST        = 16'd1;
	localparam logic [15:0] GAIN_D_RST        = 16'd100;
	localparam logic [31:0] TARGET_PERIOD_RST = 32'd36000;
	localparam logic [15:0] STALL_LIMIT_RST   = 16'd3000;

	localparam logic [9:0] DUTY_MAX   = 10'd1023;
	localparam int unsigned DUTY_STEPS = 1024;

	// Reciprocal of the divisor scaled by 2^31; the estimate it gives is low by at most one.
	localparam int RECIP_SHIFT = 31;
	localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / GAIN_DIVISOR);
	// Controller outputs at or above this value clamp to full scale.
	localparam logic [30:0] SAT_LIMIT = 31'(64'(DUTY_STEPS) * 64'(GAIN_DIVISOR));
	localparam int QUOT_W = 11;

	typedef struct packed {
		logic        vld;
		logic        cap;
		logic        stalled;
		logic [31:0] period;
	} pmpid_tag_t;

endpackage

// File: rtl/pmpid_if.sv
// Handshake channels of the speed loop: input items and result items.
// Valid/ready handshake; depends on nothing else.
interface pmpid_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [9:0] capture_value;

	modport source(output valid, output op, output capture_value, input ready);
	modport sink(input valid, input op, input capture_value, output ready);
endinterface

interface pmpid_result_if;
	logic        valid;
	logic        ready;
	logic [9:0]  duty;
	logic [31:0] period;
	logic        stalled;

	modport source(output valid, output duty, output period, output stalled, input ready);
	modport sink(input valid, input duty, input period, input stalled, output ready);
endinterface

// File: rtl/period_measuring_pid_speed_loop_top.sv
// Period-measuring PID speed loop, top level.
// A result is offered once its item has passed through the stage registers and the output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (arst_n low) clears the pipeline and state, sets duty to full scale and
// loads the register defaults; the block takes items in the first cycle after.
module period_measuring_pid_speed_loop_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pmpid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmpid_pkg::CFG_DATA_W-1:0] cfg_data,
	pmpid_item_if.sink                      item,
	pmpid_result_if.source                  result
);
	import pmpid_pkg::*;

	logic [15:0] gain_p_q;
	logic [15:0] gain_i_q;
	logic [15:0] gain_d_q;
	logic [31:0] target_period_q;
	logic [15:0] stall_limit_q;

	logic        en;
	logic        accept;
	pmpid_tag_t  tag_s2;
	pmpid_tag_t  tag_s4;
	pmpid_tag_t  tag_s6;
	logic [31:0] err_s2;
	logic [31:0] sum_s2;
	logic [31:0] diff_s2;
	logic [31:0] acc_s4;
	logic [9:0]  duty_calc;

	logic        out_vld_q;
	logic [9:0]  duty_q;
	logic [31:0] period_q;
	logic        stalled_q;

	assign en     = !out_vld_q || result.ready;
	assign accept = item.valid && en;
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q        <= GAIN_P_RST;
			gain_i_q        <= GAIN_I_RST;
			gain_d_q        <= GAIN_D_RST;
			target_period_q <= TARGET_PERIOD_RST;
			stall_limit_q   <= STALL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN_P:        gain_p_q        <= cfg_data[15:0];
				CFG_GAIN_I:        gain_i_q        <= cfg_data[15:0];
				CFG_GAIN_D:        gain_d_q        <= cfg_data[15:0];
				CFG_TARGET_PERIOD: target_period_q <= cfg_data[31:0];
				CFG_STALL_LIMIT:   stall_limit_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	pmpid_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.accept       (accept),
		.op           (item.op),
		.capture_value(item.capture_value),
		.stall_limit  (stall_limit_q),
		.target_period(target_period_q),
		.tag_s2       (tag_s2),
		.err_s2       (err_s2),
		.sum_s2       (sum_s2),
		.diff_s2      (diff_s2)
	);

	pmpid_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.gain_p ($signed(gain_p_q)),
		.gain_i ($signed(gain_i_q)),
		.gain_d ($signed(gain_d_q)),
		.tag_s2 (tag_s2),
		.err_s2 (err_s2),
		.sum_s2 (sum_s2),
		.diff_s2(diff_s2),
		.tag_s4 (tag_s4),
		.acc_s4 (acc_s4)
	);

	pmpid_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.tag_s4   (tag_s4),
		.acc_s4   (acc_s4),
		.tag_s6   (tag_s6),
		.duty_calc(duty_calc)
	);

	// The duty register is updated in item order: a capture loads the new value,
	// a stalled tick forces full scale, any other tick keeps the previous duty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			duty_q    <= DUTY_MAX;
		end else if (en) begin
			out_vld_q <= tag_s6.vld;
			if (tag_s6.vld) begin
				if (tag_s6.cap) begin
					duty_q <= duty_calc;
				end else if (tag_s6.stalled) begin
					duty_q <= DUTY_MAX;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && tag_s6.vld) begin
			period_q  <= tag_s6.period;
			stalled_q <= tag_s6.stalled;
		end
	end

	assign result.valid   = out_vld_q;
	assign result.duty    = duty_q;
	assign result.period  = period_q;
	assign result.stalled = stalled_q;

endmodule

// File: rtl/pmpid_front.sv
// Measurement front end: overflow count, period and error state (stages 1 and 2).
// Uses pmpid_pkg for the timer constant and the stage tag.
module pmpid_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                accept,
	input  logic                op,
	input  logic [9:0]          capture_value,
	input  logic [15:0]         stall_limit,
	input  logic [31:0]         target_period,
	output pmpid_pkg::pmpid_tag_t tag_s2,
	output logic [31:0]         err_s2,
	output logic [31:0]         sum_s2,
	output logic [31:0]         diff_s2
);
	import pmpid_pkg::*;

	logic [15:0] count_q;
	logic [9:0]  last_cap_q;
	logic [31:0] period_q;
	logic [31:0] err_sum_q;
	logic [31:0] last_err_q;
	pmpid_tag_t  tag_s1;

	logic [15:0] count_nxt;
	logic [31:0] span;
	logic [31:0] period_nxt;
	logic [31:0] err;
	logic [31:0] sum_nxt;

	always_comb begin
		count_nxt = op ? 16'd0 : 16'(count_q + 16'd1);
		span = 32'(count_q * TIMER_TOP);
		period_nxt = op ? (span + 32'(capture_value) - 32'(last_cap_q)) : period_q;
		err = tag_s1.period - target_period;
		sum_nxt = err_sum_q + err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			last_cap_q <= '0;
			period_q   <= '0;
			err_sum_q  <= '0;
			last_err_q <= '0;
			tag_s1     <= '0;
			tag_s2     <= '0;
		end else if (en) begin
			tag_s1.vld <= accept;
			if (accept) begin
				count_q        <= count_nxt;
				period_q       <= period_nxt;
				tag_s1.cap     <= op;
				tag_s1.stalled <= count_nxt > stall_limit;
				tag_s1.period  <= period_nxt;
				if (op) begin
					last_cap_q <= capture_value;
				end
			end
			tag_s2 <= tag_s1;
			// Integral and previous error move only on a capture.
			if (tag_s1.vld && tag_s1.cap) begin
				err_sum_q  <= sum_nxt;
				last_err_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s2  <= err;
			sum_s2  <= sum_nxt;
			diff_s2 <= err - last_err_q;
		end
	end

endmodule

// File: rtl/pmpid_mac.sv
// PID products and their sum (stages 3 and 4), all wrapping at 32 bits.
// Uses pmpid_pkg for the stage tag.
module pmpid_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic signed [15:0]    gain_p,
	input  logic signed [15:0]    gain_i,
	input  logic signed [15:0]    gain_d,
	input  pmpid_pkg::pmpid_tag_t tag_s2,
	input  logic [31:0]           err_s2,
	input  logic [31:0]           sum_s2,
	input  logic [31:0]           diff_s2,
	output pmpid_pkg::pmpid_tag_t tag_s4,
	output logic [31:0]           acc_s4
);
	import pmpid_pkg::*;

	pmpid_tag_t         tag_s3;
	logic [31:0]        p_s3;
	logic [31:0]        i_s3;
	logic [31:0]        d_s3;
	logic signed [47:0] full_p;
	logic signed [47:0] full_i;
	logic signed [47:0] full_d;

	// Only the low 32 bits are kept, so signedness of the error terms does not matter.
	assign full_p = gain_p * $signed(err_s2);
	assign full_i = gain_i * $signed(sum_s2);
	assign full_d = gain_d * $signed(diff_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (en) begin
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3   <= full_p[31:0];
			i_s3   <= full_i[31:0];
			d_s3   <= full_d[31:0];
			acc_s4 <= p_s3 + i_s3 + d_s3;
		end
	end

endmodule

// File: rtl/pmpid_scale.sv
// Scales the controller output by the gain divisor and clamps it to the duty range.
// Stages 5 and 6; the divide is a reciprocal multiply with one correction step.
// Uses pmpid_pkg for the divisor constants and the stage tag.
module pmpid_scale (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  pmpid_pkg::pmpid_tag_t tag_s4,
	input  logic [31:0]           acc_s4,
	output pmpid_pkg::pmpid_tag_t tag_s6,
	output logic [9:0]            duty_calc
);
	import pmpid_pkg::*;

	pmpid_tag_t        tag_s5;
	logic [30:0]       mag_s5;
	logic [30:0]       mag_s6;
	logic [QUOT_W-1:0] q0_s5;
	logic [QUOT_W-1:0] q0_s6;
	logic              neg_s5;
	logic              neg_s6;
	logic              sat_s5;
	logic              sat_s6;
	logic [30:0]       qd_s6;

	logic [62:0] recip_prod;
	logic [30:0] rem;
	logic [11:0] quot;

	assign recip_prod = 63'(acc_s4[30:0]) * 63'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
			tag_s6 <= '0;
		end else if (en) begin
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5 <= acc_s4[30:0];
			neg_s5 <= acc_s4[31];
			sat_s5 <= acc_s4[30:0] >= SAT_LIMIT;
			// Below the clamp limit the quotient fits in QUOT_W bits.
			q0_s5  <= recip_prod[RECIP_SHIFT +: QUOT_W];
			mag_s6 <= mag_s5;
			neg_s6 <= neg_s5;
			sat_s6 <= sat_s5;
			q0_s6  <= q0_s5;
			qd_s6  <= 31'(q0_s5 * GAIN_DIVISOR);
		end
	end

	// The estimate is at most one short; the remainder tells whether to add it.
	always_comb begin
		rem  = mag_s6 - qd_s6;
		quot = 12'(q0_s6) + 12'(rem >= 31'(GAIN_DIVISOR));
		if (neg_s6) begin
			duty_calc = '0;
		end else if (sat_s6 || quot > 12'(DUTY_MAX)) begin
			duty_calc = DUTY_MAX;
		end else begin
			duty_calc = quot[9:0];
		end
	end

endmodule

// File: rtl/pmpid_chk.sv
// Port-level checks for the speed loop, bound to the top level.
// Uses pmpid_pkg for the full-scale duty constant.
module pmpid_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [9:0]  duty,
	input logic [31:0] period,
	input logic        stalled
);
	import pmpid_pkg::*;

	// A result that is not taken stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(duty) &&
		$stable(period) && $stable(stalled))
		else $error("result changed while stalled");

	// A stall is reported only together with full-scale drive.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && stalled |-> duty == DUTY_MAX)
		else $error("stalled result without full-scale duty");

	// With no result waiting, the pipeline always takes a new item.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input not ready while output is empty");

	// A waiting result freezes the pipeline, so no item is taken.
	a_ready_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("input ready while a result is blocked");

endmodule

bind period_measuring_pid_speed_loop_top pmpid_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.duty        (result.duty),
	.period      (result.period),
	.stalled     (result.stalled)
);
